// ===== rtl/fqe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqe_pkg
// Shared types, constants and helpers of the flow quota enforcer.
// ----------------------------------------------------------------------------
package fqe_pkg;

    localparam int unsigned AddrW      = 5;
    localparam int unsigned LimW       = 42;   // 32-bit limit times 1000
    localparam logic [9:0]  MsPerSec   = 10'd1000;
    localparam logic [1:0]  FinClosed  = 2'd2;
    localparam logic [1:0]  FinMax     = 2'd3;

    // register indexes, byte address = 4 * index
    typedef enum logic [2:0] {
        REG_A_FIRST = 3'd0,
        REG_A_LAST  = 3'd1,
        REG_A_TIME  = 3'd2,
        REG_A_LIMIT = 3'd3,
        REG_B_FIRST = 3'd4,
        REG_B_LAST  = 3'd5,
        REG_B_TIME  = 3'd6,
        REG_B_LIMIT = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] remote_addr;
        logic [15:0] remote_port;
        logic [15:0] local_port;
        logic [31:0] bytes;
        logic [31:0] start_ms;
        logic [1:0]  fin_count;
        logic [31:0] closed_ms;
    } t_flow_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RULE,
        S_LK_RD,
        S_LK_CMP,
        S_UPD,
        S_SUM_RD,
        S_SUM_ADD,
        S_SUM_OPEN,
        S_MUL,
        S_CHK,
        S_INS,
        S_NEXT,
        S_OUT
    } t_state;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ===== rtl/fqe_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqe_pkt_if / fqe_res_if
// Valid/ready channels for packet summaries and verdicts.
// ----------------------------------------------------------------------------
interface fqe_pkt_if;
    logic        valid;
    logic        ready;
    logic [31:0] remote_addr;
    logic [15:0] remote_port;
    logic [15:0] local_port;
    logic        syn_flag;
    logic        fin_flag;
    logic [15:0] packet_bytes;
    logic [31:0] now_ms;

    modport source (output valid, remote_addr, remote_port, local_port, syn_flag,
                    fin_flag, packet_bytes, now_ms, input ready);
    modport sink   (input valid, remote_addr, remote_port, local_port, syn_flag,
                    fin_flag, packet_bytes, now_ms, output ready);
endinterface

interface fqe_res_if;
    logic valid;
    logic ready;
    logic drop;
    logic table_full;

    modport source (output valid, drop, table_full, input ready);
    modport sink   (input valid, drop, table_full, output ready);
endinterface

// ===== rtl/flow_quota_enforcer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_quota_enforcer_unit
// Per-flow byte/time accounting with two address-range quota rules.
// ----------------------------------------------------------------------------
// Usage:
//   i_pkt  : one packet summary per transaction (valid/ready).
//   o_res  : one verdict per packet (drop, table_full), valid/ready.
//   APB    : eight rule registers at byte addresses 0x00..0x1C; reads return
//            current values; the user must write only while idle (unenforced).
// Operation: one packet at a time. Ready is high only when idle. For each rule
//   (a, then b) whose range covers the address, the flow table is scanned
//   through a single memory read port for the flow lookup; on a miss a new
//   entry is inserted if there is room, else table_full is set. On a hit
//   the flow is updated once per packet, then the table is scanned again to
//   total the address's bytes or milliseconds (an open interval takes the
//   extra state S_SUM_OPEN), and the total is checked against the limit.
// Reset: rules get empty ranges (first above last), the table is emptied by
//   clearing the fill count; memory contents are not cleared.
// Stall: the verdict sits in S_OUT until o_res.ready; no new packet is taken
//   meanwhile.
// ----------------------------------------------------------------------------
module flow_quota_enforcer_unit #(
    parameter int unsigned FLOWS = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    fqe_pkt_if.sink                   i_pkt,
    fqe_res_if.source                 o_res,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [fqe_pkg::AddrW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import fqe_pkg::*;

    localparam int unsigned IW = $clog2(FLOWS);
    localparam int unsigned CW = $clog2(FLOWS + 1);
    localparam logic [CW-1:0] FullCnt = CW'(FLOWS);

    // rule registers, index 0 = rule a
    logic [31:0] r_first [2];
    logic [31:0] r_last  [2];
    logic        r_time  [2];
    logic [31:0] r_limit [2];

    // captured packet
    logic [31:0] r_addr;
    logic [15:0] r_rport;
    logic [15:0] r_lport;
    logic        r_syn;
    logic        r_fin;
    logic [15:0] r_len;
    logic [31:0] r_now;

    t_state        r_state, n_state;
    logic          r_rule, n_rule;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_fill, n_fill;
    logic          r_updated, n_updated;
    logic          r_drop, n_drop;
    logic          r_full, n_full;
    logic [31:0]   r_sum, n_sum;
    logic [LimW-1:0] r_lim, n_lim;

    // memory port
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_flow_entry   mem_wdata;
    t_flow_entry   mem_rdata;

    t_flow_entry   upd_entry;
    t_flow_entry   new_entry;
    logic          rule_match;
    logic          key_match;
    logic          addr_match;

    fqe_flow_mem #(.FLOWS(FLOWS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (mem_rdata)
    );

    // ---- configuration port ----
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first[0] <= 32'hFFFF_FFFF;
            r_first[1] <= 32'hFFFF_FFFF;
            r_last[0]  <= 32'd0;
            r_last[1]  <= 32'd0;
            r_time[0]  <= 1'b0;
            r_time[1]  <= 1'b0;
            r_limit[0] <= 32'hFFFF_FFFF;
            r_limit[1] <= 32'hFFFF_FFFF;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_idx'(paddr[4:2]))
                REG_A_FIRST: r_first[0] <= pwdata;
                REG_A_LAST:  r_last[0]  <= pwdata;
                REG_A_TIME:  r_time[0]  <= pwdata[0];
                REG_A_LIMIT: r_limit[0] <= pwdata;
                REG_B_FIRST: r_first[1] <= pwdata;
                REG_B_LAST:  r_last[1]  <= pwdata;
                REG_B_TIME:  r_time[1]  <= pwdata[0];
                REG_B_LIMIT: r_limit[1] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[4:2]))
            REG_A_FIRST: prdata = r_first[0];
            REG_A_LAST:  prdata = r_last[0];
            REG_A_TIME:  prdata = {31'd0, r_time[0]};
            REG_A_LIMIT: prdata = r_limit[0];
            REG_B_FIRST: prdata = r_first[1];
            REG_B_LAST:  prdata = r_last[1];
            REG_B_TIME:  prdata = {31'd0, r_time[1]};
            REG_B_LIMIT: prdata = r_limit[1];
            default:     prdata = 32'd0;
        endcase
    end

    // ---- packet capture ----
    always_ff @(posedge i_clk) begin
        if (i_pkt.valid && i_pkt.ready) begin
            r_addr  <= i_pkt.remote_addr;
            r_rport <= i_pkt.remote_port;
            r_lport <= i_pkt.local_port;
            r_syn   <= i_pkt.syn_flag;
            r_fin   <= i_pkt.fin_flag;
            r_len   <= i_pkt.packet_bytes;
            r_now   <= i_pkt.now_ms;
        end
    end

    // ---- compare and update datapath ----
    assign rule_match = (r_addr >= r_first[r_rule]) && (r_addr <= r_last[r_rule]);
    assign addr_match = (mem_rdata.remote_addr == r_addr);
    assign key_match  = addr_match && (mem_rdata.remote_port == r_rport)
                        && (mem_rdata.local_port == r_lport);

    // per-packet flow update: FIN counting, interval close, SYN reopen, bytes
    always_comb begin
        upd_entry = mem_rdata;
        if (r_fin) begin
            if (upd_entry.fin_count < FinMax) begin
                upd_entry.fin_count = upd_entry.fin_count + 2'd1;
            end
            if (upd_entry.fin_count == FinClosed) begin
                upd_entry.closed_ms = sat_add(mem_rdata.closed_ms,
                                              r_now - mem_rdata.start_ms);
                upd_entry.start_ms  = r_now;
            end
        end
        if (r_syn && upd_entry.fin_count == FinClosed) begin
            upd_entry.start_ms  = r_now;
            upd_entry.fin_count = 2'd0;
        end
        upd_entry.bytes = sat_add(mem_rdata.bytes, {16'd0, r_len});
    end

    always_comb begin
        new_entry.remote_addr = r_addr;
        new_entry.remote_port = r_rport;
        new_entry.local_port  = r_lport;
        new_entry.bytes       = 32'd0;
        new_entry.start_ms    = r_now;
        new_entry.fin_count   = 2'd0;
        new_entry.closed_ms   = 32'd0;
    end

    // ---- sequencer: next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_pkt.valid) begin n_state = S_RULE; end
            S_RULE:     n_state = rule_match ? S_LK_RD : S_NEXT;
            S_LK_RD:    n_state = (r_idx == r_fill) ? S_INS : S_LK_CMP;
            S_LK_CMP: begin
                if (key_match) begin
                    n_state = r_updated ? S_SUM_RD : S_UPD;
                end else begin
                    n_state = S_LK_RD;
                end
            end
            S_UPD:      n_state = S_SUM_RD;
            S_SUM_RD:   n_state = (r_idx == r_fill) ? S_MUL : S_SUM_ADD;
            S_SUM_ADD: begin
                if (addr_match && r_time[r_rule] && mem_rdata.fin_count < FinClosed) begin
                    n_state = S_SUM_OPEN;
                end else begin
                    n_state = S_SUM_RD;
                end
            end
            S_SUM_OPEN: n_state = S_SUM_RD;
            S_MUL:      n_state = S_CHK;
            S_CHK:      n_state = S_NEXT;
            S_INS:      n_state = S_NEXT;
            S_NEXT:     n_state = r_rule ? S_OUT : S_RULE;
            S_OUT:      if (o_res.ready) begin n_state = S_IDLE; end
            default:    n_state = S_IDLE;
        endcase
    end

    // ---- sequencer: datapath and outputs ----
    always_comb begin
        n_rule    = r_rule;
        n_idx     = r_idx;
        n_fill    = r_fill;
        n_updated = r_updated;
        n_drop    = r_drop;
        n_full    = r_full;
        n_sum     = r_sum;
        n_lim     = r_lim;
        mem_we    = 1'b0;
        mem_waddr = r_idx[IW-1:0];
        mem_wdata = upd_entry;
        unique case (r_state)
            S_IDLE: begin
                n_rule    = 1'b0;
                n_updated = 1'b0;
                n_drop    = 1'b0;
                n_full    = 1'b0;
            end
            S_RULE: begin
                n_idx = '0;
            end
            S_LK_RD: ;
            S_LK_CMP: begin
                if (key_match) begin
                    if (r_updated) begin
                        n_idx = '0;
                        n_sum = 32'd0;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_UPD: begin
                mem_we    = 1'b1;
                n_updated = 1'b1;
                n_idx     = '0;
                n_sum     = 32'd0;
            end
            S_SUM_RD: ;
            S_SUM_ADD: begin
                if (addr_match) begin
                    n_sum = sat_add(r_sum, r_time[r_rule] ? mem_rdata.closed_ms
                                                          : mem_rdata.bytes);
                end
                if (!(addr_match && r_time[r_rule] && mem_rdata.fin_count < FinClosed)) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SUM_OPEN: begin
                n_sum = sat_add(r_sum, r_now - mem_rdata.start_ms);
                n_idx = r_idx + 1'b1;
            end
            S_MUL: begin
                n_lim = r_time[r_rule] ? LimW'(r_limit[r_rule] * MsPerSec)
                                       : LimW'(r_limit[r_rule]);
            end
            S_CHK: begin
                if (LimW'(r_sum) > r_lim) begin
                    n_drop = 1'b1;
                end
            end
            S_INS: begin
                if (r_fill == FullCnt) begin
                    n_full = 1'b1;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_fill[IW-1:0];
                    mem_wdata = new_entry;
                    n_fill    = r_fill + 1'b1;
                end
            end
            S_NEXT: begin
                n_rule = 1'b1;
            end
            S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rule    <= 1'b0;
            r_idx     <= '0;
            r_fill    <= '0;
            r_updated <= 1'b0;
            r_drop    <= 1'b0;
            r_full    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rule    <= n_rule;
            r_idx     <= n_idx;
            r_fill    <= n_fill;
            r_updated <= n_updated;
            r_drop    <= n_drop;
            r_full    <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        r_lim <= n_lim;
    end

    assign i_pkt.ready      = (r_state == S_IDLE);
    assign o_res.valid      = (r_state == S_OUT);
    assign o_res.drop       = r_drop;
    assign o_res.table_full = r_full;

endmodule

// ===== rtl/fqe_flow_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqe_flow_mem
// Flow table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fqe_flow_mem #(
    parameter int unsigned FLOWS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(FLOWS)-1:0]   i_waddr,
    input  fqe_pkg::t_flow_entry       i_wdata,
    input  logic [$clog2(FLOWS)-1:0]   i_raddr,
    output fqe_pkg::t_flow_entry       o_rdata
);
    import fqe_pkg::*;

    t_flow_entry r_mem [FLOWS];
    t_flow_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fqe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqe_checker
// Port-level checks of the flow quota enforcer, bound to the top level.
// ----------------------------------------------------------------------------
module fqe_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_drop,
    input logic i_full,
    input logic i_pready
);

    // APB never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pready)
        else $error("pready low");

    // one packet in flight: no intake while a verdict is pending
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while verdict pending");

    // verdict never in the cycle right after intake
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_out_valid)
        else $error("verdict too early");

    // stalled verdict holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_drop)
                                           && $stable(i_full)))
        else $error("stalled verdict changed");

endmodule

bind flow_quota_enforcer_unit fqe_checker u_fqe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pkt.valid),
    .i_in_ready  (i_pkt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_drop      (o_res.drop),
    .i_full      (o_res.table_full),
    .i_pready    (pready)
);

// ===== sim/flow_quota_enforcer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_quota_enforcer_unit_tb
// Self-checking bench for the flow quota enforcer. Packet summaries are queued
// by an initial block and driven through the valid/ready channel; a local
// flow-table model predicts drop/table_full for each accepted transaction and
// the monitor compares every verdict in order. Rules are reprogrammed over APB
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module flow_quota_enforcer_unit_tb;
    import fqe_pkg::*;

    localparam int NFLOWS    = 64;
    localparam int CYC_LIMIT = 8000000;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] rport;
        logic [15:0] lport;
        logic        syn;
        logic        fin;
        logic [15:0] len;
        logic [31:0] now;
    } t_pkt;

    typedef struct packed {
        logic drop;
        logic full;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    fqe_pkt_if pkt_ch ();
    fqe_res_if res_ch ();

    flow_quota_enforcer_unit #(.FLOWS(NFLOWS)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_ch.sink),
        .o_res   (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    // ---------------- predictor state ----------------
    logic [31:0] rl_first [2];
    logic [31:0] rl_last  [2];
    logic        rl_time  [2];
    logic [31:0] rl_limit [2];

    logic        ft_valid [NFLOWS];
    logic [31:0] ft_addr  [NFLOWS];
    logic [15:0] ft_rport [NFLOWS];
    logic [15:0] ft_lport [NFLOWS];
    logic [31:0] ft_bytes [NFLOWS];
    logic [31:0] ft_start [NFLOWS];
    logic [1:0]  ft_fins  [NFLOWS];
    logic [31:0] ft_closed[NFLOWS];

    t_pkt     pending_pkts[$];
    t_verdict expected_verdicts[$];
    int       n_errors = 0;
    int       cycles = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       hold_off = 0;   // long receiver stall, cycles left

    function automatic logic [31:0] qsum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic t_verdict predict_verdict(t_pkt p);
        t_verdict v;
        logic     updated;
        int       hit, slot;
        logic [31:0] total;
        logic [41:0] lim_ms;
        v = '0;
        updated = 1'b0;
        for (int r = 0; r < 2; r++) begin
            if (p.addr < rl_first[r] || p.addr > rl_last[r]) continue;
            hit = -1;
            for (int k = 0; k < NFLOWS; k++) begin
                if (hit < 0 && ft_valid[k] && ft_addr[k] == p.addr &&
                    ft_rport[k] == p.rport && ft_lport[k] == p.lport) hit = k;
            end
            if (hit >= 0) begin
                if (!updated) begin
                    updated = 1'b1;
                    if (p.fin) begin
                        if (ft_fins[hit] < FinMax) ft_fins[hit]++;
                        if (ft_fins[hit] == FinClosed) begin
                            ft_closed[hit] = qsum(ft_closed[hit], p.now - ft_start[hit]);
                            ft_start[hit] = p.now;
                        end
                    end
                    if (p.syn && ft_fins[hit] == FinClosed) begin
                        ft_start[hit] = p.now;
                        ft_fins[hit] = 2'd0;
                    end
                    ft_bytes[hit] = qsum(ft_bytes[hit], {16'd0, p.len});
                end
                total = '0;
                for (int k = 0; k < NFLOWS; k++) begin
                    if (ft_valid[k] && ft_addr[k] == p.addr) begin
                        if (rl_time[r]) begin
                            total = qsum(total, ft_closed[k]);
                            if (ft_fins[k] < FinClosed)
                                total = qsum(total, p.now - ft_start[k]);
                        end else begin
                            total = qsum(total, ft_bytes[k]);
                        end
                    end
                end
                lim_ms = 42'(rl_limit[r]) * 42'd1000;
                if (rl_time[r] ? (42'(total) > lim_ms) : (total > rl_limit[r]))
                    v.drop = 1'b1;
            end else begin
                slot = -1;
                for (int k = 0; k < NFLOWS; k++)
                    if (slot < 0 && !ft_valid[k]) slot = k;
                if (slot < 0) begin
                    v.full = 1'b1;
                end else begin
                    ft_valid[slot]  = 1'b1;
                    ft_addr[slot]   = p.addr;
                    ft_rport[slot]  = p.rport;
                    ft_lport[slot]  = p.lport;
                    ft_bytes[slot]  = '0;
                    ft_start[slot]  = p.now;
                    ft_fins[slot]   = 2'd0;
                    ft_closed[slot] = '0;
                end
            end
        end
        return v;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch @%0t: %s", $realtime, what);
        n_errors++;
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pkt_ch.valid <= 1'b0;
        end else if (!pkt_ch.valid || pkt_ch.ready) begin
            // previous transaction (if any) accepted at this edge
            if (pending_pkts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_pkt p;
                p = pending_pkts.pop_front();
                pkt_ch.valid        <= 1'b1;
                pkt_ch.remote_addr  <= p.addr;
                pkt_ch.remote_port  <= p.rport;
                pkt_ch.local_port   <= p.lport;
                pkt_ch.syn_flag     <= p.syn;
                pkt_ch.fin_flag     <= p.fin;
                pkt_ch.packet_bytes <= p.len;
                pkt_ch.now_ms       <= p.now;
            end else begin
                pkt_ch.valid <= 1'b0;
            end
        end
    end

    // prediction at acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && pkt_ch.valid && pkt_ch.ready)
            expected_verdicts.push_back(predict_verdict({pkt_ch.remote_addr,
                pkt_ch.remote_port, pkt_ch.local_port, pkt_ch.syn_flag,
                pkt_ch.fin_flag, pkt_ch.packet_bytes, pkt_ch.now_ms}));
    end

    // ---------------- receiver + monitor ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
            if (res_ch.valid && res_ch.ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("verdict with nothing expected");
                end else begin
                    t_verdict e;
                    e = expected_verdicts.pop_front();
                    if (res_ch.drop !== e.drop)
                        report_mismatch($sformatf("drop %b want %b", res_ch.drop, e.drop));
                    if (res_ch.table_full !== e.full)
                        report_mismatch($sformatf("table_full %b want %b",
                                                  res_ch.table_full, e.full));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYC_LIMIT) begin
            $display("[flow_quota_enforcer_unit] ERROR");
            $finish;
        end
    end

    // ---------------- APB write ----------------
    task automatic apb_write(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_A_FIRST: rl_first[0] = val;
            REG_A_LAST:  rl_last[0]  = val;
            REG_A_TIME:  rl_time[0]  = val[0];
            REG_A_LIMIT: rl_limit[0] = val;
            REG_B_FIRST: rl_first[1] = val;
            REG_B_LAST:  rl_last[1]  = val;
            REG_B_TIME:  rl_time[1]  = val[0];
            default:     rl_limit[1] = val;
        endcase
    endtask

    task automatic set_rules(logic [31:0] af, logic [31:0] al, logic at, logic [31:0] alim,
                             logic [31:0] bf, logic [31:0] bl, logic bt, logic [31:0] blim);
        apb_write(REG_A_FIRST, af);
        apb_write(REG_A_LAST, al);
        apb_write(REG_A_TIME, {31'd0, at});
        apb_write(REG_A_LIMIT, alim);
        apb_write(REG_B_FIRST, bf);
        apb_write(REG_B_LAST, bl);
        apb_write(REG_B_TIME, {31'd0, bt});
        apb_write(REG_B_LIMIT, blim);
    endtask

    // wait for all verdicts, then let the block settle before reprogramming
    task automatic drain();
        while (pending_pkts.size() > 0 || pkt_ch.valid || expected_verdicts.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic add_pkt(logic [31:0] a, logic [15:0] rp, logic [15:0] lp, logic s,
                           logic f, logic [15:0] len, logic [31:0] t);
        pending_pkts.push_back({a, rp, lp, s, f, len, t});
    endtask

    // Random flow traffic: a small pool of addresses/ports so flows repeat,
    // timestamps moving forward with occasional wrap jumps.
    logic [31:0] clock_ms = 32'd0;
    task automatic add_random(int n, logic [31:0] base, int span);
        logic [31:0] a;
        for (int i = 0; i < n; i++) begin
            clock_ms = clock_ms + $urandom_range(3000);
            if ($urandom_range(99) < 3) clock_ms = $urandom;
            if ($urandom_range(99) < 8) a = $urandom;
            else a = base + $urandom_range(span);
            add_pkt(a, ($urandom_range(99) < 85) ? 16'($urandom_range(3)) : 16'($urandom),
                    ($urandom_range(99) < 85) ? 16'(80 + $urandom_range(1)) : 16'($urandom),
                    $urandom_range(99) < 20, $urandom_range(99) < 30,
                    ($urandom_range(99) < 5) ? 16'hFFFF : 16'($urandom_range(1500)),
                    clock_ms);
        end
    endtask

    task automatic reset_table_model();
        for (int k = 0; k < NFLOWS; k++) ft_valid[k] = 1'b0;
    endtask

    initial begin
        pkt_ch.valid = 1'b0;
        pkt_ch.remote_addr = '0;
        pkt_ch.remote_port = '0;
        pkt_ch.local_port = '0;
        pkt_ch.syn_flag = 1'b0;
        pkt_ch.fin_flag = 1'b0;
        pkt_ch.packet_bytes = '0;
        pkt_ch.now_ms = '0;
        res_ch.ready = 1'b0;
        for (int r = 0; r < 2; r++) begin
            rl_first[r] = 32'hFFFF_FFFF;
            rl_last[r]  = '0;
            rl_time[r]  = 1'b0;
            rl_limit[r] = 32'hFFFF_FFFF;
        end
        reset_table_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (5) @(posedge i_clk);

        // after reset both ranges are empty: nothing matches
        add_pkt(32'h0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 32'h0);
        add_pkt(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        drain();

        // directed: both rules cover everything; rule a bytes, rule b time
        set_rules(32'h0, 32'hFFFF_FFFF, 1'b0, 32'd2000, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'd5);
        add_pkt(32'h0A00_0001, 16'd1, 16'd80, 1'b1, 1'b0, 16'd1000, 32'd100);  // both match new
        add_pkt(32'h0A00_0001, 16'd1, 16'd80, 1'b0, 1'b0, 16'd1500, 32'd200);  // bytes over
        add_pkt(32'h0A00_0001, 16'd1, 16'd80, 1'b0, 1'b1, 16'd0, 32'd300);     // first FIN
        add_pkt(32'h0A00_0001, 16'd1, 16'd80, 1'b0, 1'b1, 16'd0, 32'd7000);    // closed
        add_pkt(32'h0A00_0001, 16'd1, 16'd80, 1'b1, 1'b0, 16'd0, 32'd9000);    // reopen
        add_pkt(32'h0A00_0001, 16'd1, 16'd80, 1'b0, 1'b1, 16'd0, 32'd9100);
        add_pkt(32'h0A00_0001, 16'd1, 16'd80, 1'b0, 1'b1, 16'd0, 32'd9200);
        add_pkt(32'h0A00_0001, 16'd1, 16'd80, 1'b0, 1'b1, 16'd0, 32'd9300);    // FIN saturates
        add_pkt(32'h0A00_0001, 16'd2, 16'd80, 1'b0, 1'b0, 16'hFFFF, 32'hFFFF_FF00);
        add_pkt(32'h0A00_0001, 16'd2, 16'd80, 1'b0, 1'b0, 16'hFFFF, 32'h0000_0100); // wrap
        add_pkt(32'h0, 16'h0, 16'h0, 1'b0, 1'b0, 16'hFFFF, 32'h0);
        add_pkt(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 16'hFFFF, 32'hFFFF_FFFF);
        // fill the table with distinct flows, then overflow it
        for (int i = 0; i < NFLOWS; i++)
            add_pkt(32'h0B00_0000, 16'(i), 16'd443, 1'b0, 1'b0, 16'd10, 32'(i));
        drain();

        // phase 1: sender 15%, receiver 72%; table full, limits at extremes
        send_idle_pct = 15; recv_idle_pct = 72;
        set_rules(32'h0B00_0000, 32'h0B00_0000, 1'b1, 32'hFFFF_FFFF,
                  32'h0, 32'hFFFF_FFFF, 1'b0, 32'd0);
        add_random(300, 32'h0B00_0000, 0);
        drain();

        // table contents persist; no further reset, so later phases see a full
        // table unless flows repeat. Keep pools on known addresses.
        send_idle_pct = 72; recv_idle_pct = 15;
        set_rules(32'h0A00_0000, 32'h0A00_0010, 1'b0, 32'd50000,
                  32'h0B00_0000, 32'h0B00_0001, 1'b1, 32'd3);
        add_random(400, 32'h0A00_0001, 1);
        hold_off <= 400;   // long stall while the sender keeps offering
        drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        set_rules(32'h0, 32'hFFFF_FFFF, 1'b1, 32'd0, 32'h0B00_0000, 32'hFFFF_FFFF,
                  1'b0, 32'hFFFF_FFFF);
        add_random(600, 32'h0B00_0000, 0);
        drain();

        set_rules(32'h0A00_0000, 32'h0B00_0000, 1'b0, 32'd100000,
                  32'hFFFF_FFFF, 32'h0, 1'b1, 32'd10);
        add_random(560, 32'h0A00_0001, 0);
        drain();

        if (n_errors == 0) begin
            $display("[flow_quota_enforcer_unit] OK");
        end else begin
            $display("[flow_quota_enforcer_unit] ERROR");
        end
        $finish;
    end
endmodule
